// ----- hw/rtl/sarl_pkg.sv -----
// sarl_pkg: shared types, constants and codes for the symbol address range lookup
// used by sarl_store, sarl_cmp and symbol_address_range_lookup
`default_nettype none

package sarl_pkg;

   // table size and derived widths
   localparam int MAX_SYMBOLS = 256;
   localparam int IDX_W       = $clog2(MAX_SYMBOLS);
   localparam int CNT_W       = IDX_W + 1;

   // field widths
   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 64;
   localparam int SIZE_W   = 64;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 8;
   localparam int COUNT_W  = 9;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXACT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAIN = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // one entry of the sorted store
   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [SIZE_W-1:0]  size;
      logic [ENTRY_W-1:0] index;
   } entry_type;

   // compare unit results
   typedef struct packed {
      logic lt;         // entry start below key
      logic eq;         // entry start equals key
      logic below_end;  // key below entry start + size
   } cmp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sarl_store.sv -----
// sarl_store: sorted symbol store, one write port and one registered read port
// depends on sarl_pkg for the entry type and depth
`default_nettype none

module sarl_store (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire [sarl_pkg::IDX_W-1:0]   wr_addr,
   input  sarl_pkg::entry_type         wr_data,
   input  wire                         rd_en,
   input  wire [sarl_pkg::IDX_W-1:0]   rd_addr,
   output sarl_pkg::entry_type         rd_data
);

   sarl_pkg::entry_type mem_ff [sarl_pkg::MAX_SYMBOLS];
   sarl_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sarl_cmp.sv -----
// sarl_cmp: shared 64-bit compare unit for search steps and range checks
// depends on sarl_pkg for widths and the result struct
`default_nettype none

module sarl_cmp (
   input  wire [sarl_pkg::ADDR_W-1:0] key,
   input  wire [sarl_pkg::ADDR_W-1:0] start,
   input  wire [sarl_pkg::SIZE_W-1:0] size,
   output sarl_pkg::cmp_type          result
);

   logic [sarl_pkg::ADDR_W-1:0] offset;

   // key against start, and key against the end without wrap
   always_comb begin
      offset           = key - start;
      result.lt        = start < key;
      result.eq        = start == key;
      result.below_end = (key < start) || (offset < size);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/symbol_address_range_lookup.sv -----
// symbol_address_range_lookup: top level with the command sequencer and result register
// depends on sarl_pkg, sarl_store and sarl_cmp
`default_nettype none

// Symbol table kept sorted by start address. Requests append a symbol, look up
// a symbol by exact start, look up the symbol whose range holds an address, or
// clear the table; each request gives one response carrying the global export
// and import counts. One request is worked at a time and req_stall stays high
// meanwhile. Timing is set by the single store read port with registered data
// and the one shared comparator: a search over n sorted entries takes at most
// ceil(log2(n+1)) steps, each a read then a compare. A lookup checks the entry
// at the lower bound, if any, and for a containing lookup without a match the
// one before it; an append that enters the store moves the entries from the
// lower bound up one place, then writes the new one there; clear, a full-table
// append, an append kept out of the store and a lookup of 0 or on an empty
// store go straight to the response. A held response stalls the final step. No
// clearing pass after reset: only entries below the fill count are read.
module symbol_address_range_lookup (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire [sarl_pkg::CMD_W-1:0]      req_command,
   input  wire [sarl_pkg::ADDR_W-1:0]     req_address,
   input  wire [sarl_pkg::SIZE_W-1:0]     req_symbol_size,
   input  wire                            req_is_global,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [sarl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sarl_pkg::ENTRY_W-1:0]   rsp_entry_index,
   output logic [sarl_pkg::COUNT_W-1:0]   rsp_export_count,
   output logic [sarl_pkg::COUNT_W-1:0]   rsp_import_count
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SRCH_RD   = 3'd1;
   localparam logic [2:0] S_SRCH_CMP  = 3'd2;
   localparam logic [2:0] S_PROBE_CMP = 3'd3;
   localparam logic [2:0] S_SHIFT     = 3'd4;
   localparam logic [2:0] S_INSERT    = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   localparam logic [sarl_pkg::CNT_W-1:0] CNT_MAX = sarl_pkg::CNT_W'(sarl_pkg::MAX_SYMBOLS);
   localparam logic [sarl_pkg::CNT_W-1:0] CNT_ONE = sarl_pkg::CNT_W'(1);

   logic [2:0] state_ff, state_in;

   // latched request
   logic [sarl_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [sarl_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [sarl_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [sarl_pkg::ENTRY_W-1:0] new_idx_ff, new_idx_in;

   // table counters
   logic [sarl_pkg::CNT_W-1:0] sorted_count_ff, sorted_count_in;
   logic [sarl_pkg::CNT_W-1:0] symbol_count_ff, symbol_count_in;
   logic [sarl_pkg::CNT_W-1:0] export_ff, export_in;
   logic [sarl_pkg::CNT_W-1:0] import_ff, import_in;

   // search and shift bookkeeping
   logic [sarl_pkg::CNT_W-1:0] lo_ff, lo_in;
   logic [sarl_pkg::CNT_W-1:0] hi_ff, hi_in;
   logic [sarl_pkg::CNT_W-1:0] mid_ff, mid_in;
   logic [sarl_pkg::CNT_W-1:0] src_ff, src_in;
   logic [sarl_pkg::CNT_W-1:0] dst_ff, dst_in;
   logic [sarl_pkg::CNT_W-1:0] left_ff, left_in;
   logic                       pend_ff, pend_in;
   logic                       prev_ff, prev_in;

   // result being built and result register
   logic [sarl_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [sarl_pkg::ENTRY_W-1:0]  res_index_ff, res_index_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sarl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [sarl_pkg::ENTRY_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [sarl_pkg::COUNT_W-1:0]  rsp_export_ff, rsp_export_in;
   logic [sarl_pkg::COUNT_W-1:0]  rsp_import_ff, rsp_import_in;

   // store and compare unit hookup
   logic                         wr_en, rd_en;
   logic [sarl_pkg::IDX_W-1:0]   wr_addr, rd_addr;
   sarl_pkg::entry_type          wr_data, rd_data;
   sarl_pkg::cmp_type            cmp;

   logic                       accept;
   logic [sarl_pkg::CNT_W-1:0] mid;
   logic                       go_right;

   sarl_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sarl_cmp u_cmp (
      .key    (addr_ff),
      .start  (rd_data.start),
      .size   (rd_data.size),
      .result (cmp)
   );

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign go_right = cmp.lt || ((cmd_ff == sarl_pkg::CMD_APPEND) && cmp.eq);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      addr_in         = addr_ff;
      size_in         = size_ff;
      new_idx_in      = new_idx_ff;
      sorted_count_in = sorted_count_ff;
      symbol_count_in = symbol_count_ff;
      export_in       = export_ff;
      import_in       = import_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      src_in          = src_ff;
      dst_in          = dst_ff;
      left_in         = left_ff;
      pend_in         = pend_ff;
      prev_in         = prev_ff;
      res_status_in   = res_status_ff;
      res_index_in    = res_index_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_export_in   = rsp_export_ff;
      rsp_import_in   = rsp_import_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '{start: addr_ff, size: size_ff, index: new_idx_ff};
      rd_en           = 1'b0;
      rd_addr         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_command;
               addr_in       = req_address;
               size_in       = req_symbol_size;
               lo_in         = '0;
               hi_in         = sorted_count_ff;
               res_status_in = sarl_pkg::ST_MISS;
               res_index_in  = '0;
               state_in      = S_DONE;
               unique case (req_command)
                  sarl_pkg::CMD_APPEND: begin
                     if (symbol_count_ff >= CNT_MAX) begin
                        res_status_in = sarl_pkg::ST_FULL;
                     end else begin
                        res_status_in   = sarl_pkg::ST_HIT;
                        res_index_in    = sarl_pkg::ENTRY_W'(symbol_count_ff);
                        new_idx_in      = sarl_pkg::ENTRY_W'(symbol_count_ff);
                        symbol_count_in = symbol_count_ff + CNT_ONE;
                        if (req_is_global) begin
                           if (req_symbol_size != '0) begin
                              export_in = export_ff + CNT_ONE;
                           end else begin
                              import_in = import_ff + CNT_ONE;
                           end
                        end
                        if ((req_address != '0) && (req_symbol_size != '0) &&
                            (sorted_count_ff < CNT_MAX)) begin
                           state_in = S_SRCH_RD;
                        end
                     end
                  end
                  sarl_pkg::CMD_EXACT, sarl_pkg::CMD_CONTAIN: begin
                     if ((req_address != '0) && (sorted_count_ff != '0)) begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  sarl_pkg::CMD_CLEAR: begin
                     res_status_in   = sarl_pkg::ST_HIT;
                     sorted_count_in = '0;
                     symbol_count_in = '0;
                     export_in       = '0;
                     import_in       = '0;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // issue a search read, or act on the finished lower bound
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid[sarl_pkg::IDX_W-1:0];
               mid_in   = mid;
               state_in = S_SRCH_CMP;
            end else if (cmd_ff == sarl_pkg::CMD_APPEND) begin
               if (lo_ff == sorted_count_ff) begin
                  state_in = S_INSERT;
               end else begin
                  src_in   = sorted_count_ff - CNT_ONE;
                  left_in  = sorted_count_ff - lo_ff;
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end
            end else if (lo_ff < sorted_count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff[sarl_pkg::IDX_W-1:0];
               prev_in  = 1'b0;
               state_in = S_PROBE_CMP;
            end else if ((cmd_ff == sarl_pkg::CMD_CONTAIN) && (lo_ff != '0)) begin
               rd_en    = 1'b1;
               rd_addr  = sarl_pkg::IDX_W'(lo_ff - CNT_ONE);
               prev_in  = 1'b1;
               state_in = S_PROBE_CMP;
            end else begin
               state_in = S_DONE;
            end
         end

         // one search step on the entry just read
         S_SRCH_CMP: begin
            if (go_right) begin
               lo_in = mid_ff + CNT_ONE;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH_RD;
         end

         // check the entry at the lower bound, then for a containing lookup the one before it
         S_PROBE_CMP: begin
            state_in = S_DONE;
            if (!prev_ff) begin
               if (cmp.eq) begin
                  res_status_in = sarl_pkg::ST_HIT;
                  res_index_in  = rd_data.index;
               end else if ((cmd_ff == sarl_pkg::CMD_CONTAIN) && (lo_ff != '0)) begin
                  rd_en    = 1'b1;
                  rd_addr  = sarl_pkg::IDX_W'(lo_ff - CNT_ONE);
                  prev_in  = 1'b1;
                  state_in = S_PROBE_CMP;
               end
            end else if (cmp.below_end) begin
               res_status_in = sarl_pkg::ST_HIT;
               res_index_in  = rd_data.index;
            end
         end

         // move entries up one place, one read and one write per cycle
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff[sarl_pkg::IDX_W-1:0];
               wr_data = rd_data;
            end
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = src_ff[sarl_pkg::IDX_W-1:0];
               dst_in  = src_ff + CNT_ONE;
               src_in  = src_ff - CNT_ONE;
               left_in = left_ff - CNT_ONE;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_INSERT;
            end
         end

         // place the new symbol at the lower bound
         S_INSERT: begin
            wr_en           = 1'b1;
            wr_addr         = lo_ff[sarl_pkg::IDX_W-1:0];
            sorted_count_in = sorted_count_ff + CNT_ONE;
            state_in        = S_DONE;
         end

         // load the response register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_export_in = sarl_pkg::COUNT_W'(export_ff);
               rsp_import_in = sarl_pkg::COUNT_W'(import_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         sorted_count_ff <= '0;
         symbol_count_ff <= '0;
         export_ff       <= '0;
         import_ff       <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sorted_count_ff <= sorted_count_in;
         symbol_count_ff <= symbol_count_in;
         export_ff       <= export_in;
         import_ff       <= import_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      new_idx_ff    <= new_idx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_export_ff <= rsp_export_in;
      rsp_import_ff <= rsp_import_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_export_count = rsp_export_ff;
   assign rsp_import_count = rsp_import_ff;

   // sorted store never holds more entries than were appended
   a_sorted_le_symbols: assert property (@(posedge clock) disable iff (reset)
      sorted_count_ff <= symbol_count_ff)
      else $error("sorted count exceeds symbol count");

   // global counts stay within the appended symbols
   a_counts_le_symbols: assert property (@(posedge clock) disable iff (reset)
      (export_ff <= symbol_count_ff) && (import_ff <= symbol_count_ff))
      else $error("global counts exceed symbol count");

   // search window stays inside the filled part of the store
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_RD) |-> ((lo_ff <= hi_ff) && (hi_ff <= sorted_count_ff)))
      else $error("search window out of range");

   // a response appears only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside done state");

   // shift never moves more entries than are stored
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (left_ff <= sorted_count_ff))
      else $error("shift count out of range");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for symbol_address_range_lookup with its own symbol
// table predictor, random request/response idling and a directed opening sequence
// depends on sarl_pkg and symbol_address_range_lookup
`default_nettype none

module testbench;

   // one predicted response
   typedef struct {
      logic [sarl_pkg::STATUS_W-1:0] status;
      logic [sarl_pkg::ENTRY_W-1:0]  entry_index;
      logic [sarl_pkg::COUNT_W-1:0]  exports;
      logic [sarl_pkg::COUNT_W-1:0]  imports;
   } table_answer_type;

   // symbol table predictor and response checker
   class symbol_table_checker_type;
      logic [sarl_pkg::ADDR_W-1:0]  starts [sarl_pkg::MAX_SYMBOLS];
      logic [sarl_pkg::SIZE_W-1:0]  sizes  [sarl_pkg::MAX_SYMBOLS];
      logic [sarl_pkg::ENTRY_W-1:0] owners [sarl_pkg::MAX_SYMBOLS];
      int unsigned                  sorted_fill;
      int unsigned                  symbols;
      logic [sarl_pkg::COUNT_W-1:0] exports;
      logic [sarl_pkg::COUNT_W-1:0] imports;
      table_answer_type             pending_answers [$];
      int unsigned                  errors;
      int unsigned                  appends, refusals, lookups, lookup_hits, clears;

      function new();
         wipe();
         errors = 0;
         appends = 0;
         refusals = 0;
         lookups = 0;
         lookup_hits = 0;
         clears = 0;
      endfunction

      function void wipe();
         sorted_fill = 0;
         symbols = 0;
         exports = '0;
         imports = '0;
      endfunction

      // first position with start >= key, or > key when past_ties is set
      function int unsigned search(logic [sarl_pkg::ADDR_W-1:0] key, bit past_ties);
         int unsigned lo, hi, mid;
         lo = 0;
         hi = sorted_fill;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (past_ties ? (starts[mid] <= key) : (starts[mid] < key))
               lo = mid + 1;
            else
               hi = mid;
         end
         return lo;
      endfunction

      // work out the response of one accepted request and queue it
      function void note_request(logic [sarl_pkg::CMD_W-1:0] command,
                                 logic [sarl_pkg::ADDR_W-1:0] address,
                                 logic [sarl_pkg::SIZE_W-1:0] size, logic global_bind);
         table_answer_type ans;
         int unsigned      pos, k;
         ans.status = sarl_pkg::ST_MISS;
         ans.entry_index = '0;
         case (command)
            sarl_pkg::CMD_APPEND: begin
               appends++;
               if (symbols >= sarl_pkg::MAX_SYMBOLS) begin
                  ans.status = sarl_pkg::ST_FULL;
                  refusals++;
               end else begin
                  if (global_bind) begin
                     if (size != 0) exports++;
                     else imports++;
                  end
                  // only real ranges go into the sorted store, after equal starts
                  if (address != 0 && size != 0 && sorted_fill < sarl_pkg::MAX_SYMBOLS) begin
                     pos = search(address, 1'b1);
                     for (k = sorted_fill; k > pos; k--) begin
                        starts[k] = starts[k-1];
                        sizes[k]  = sizes[k-1];
                        owners[k] = owners[k-1];
                     end
                     starts[pos] = address;
                     sizes[pos]  = size;
                     owners[pos] = symbols[sarl_pkg::ENTRY_W-1:0];
                     sorted_fill++;
                  end
                  ans.status = sarl_pkg::ST_HIT;
                  ans.entry_index = symbols[sarl_pkg::ENTRY_W-1:0];
                  symbols++;
               end
            end
            sarl_pkg::CMD_EXACT, sarl_pkg::CMD_CONTAIN: begin
               lookups++;
               if (address != 0 && sorted_fill > 0) begin
                  pos = search(address, 1'b0);
                  if (pos < sorted_fill && starts[pos] == address) begin
                     ans.status = sarl_pkg::ST_HIT;
                     ans.entry_index = owners[pos];
                  end else if (command == sarl_pkg::CMD_CONTAIN && pos > 0) begin
                     // end of the previous range taken as a 65-bit sum
                     if ({1'b0, address} < {1'b0, starts[pos-1]} + {1'b0, sizes[pos-1]}) begin
                        ans.status = sarl_pkg::ST_HIT;
                        ans.entry_index = owners[pos-1];
                     end
                  end
               end
               if (ans.status == sarl_pkg::ST_HIT) lookup_hits++;
            end
            default: begin
               clears++;
               wipe();
               ans.status = sarl_pkg::ST_HIT;
            end
         endcase
         ans.exports = exports;
         ans.imports = imports;
         pending_answers.insert(pending_answers.size(), ans);
      endfunction

      function void compare_field(string field, logic [8:0] expected, logic [8:0] actual);
         if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            errors++;
         end
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_response(logic [sarl_pkg::STATUS_W-1:0] status,
                                   logic [sarl_pkg::ENTRY_W-1:0] entry_index,
                                   logic [sarl_pkg::COUNT_W-1:0] exp_count,
                                   logic [sarl_pkg::COUNT_W-1:0] imp_count);
         table_answer_type ans;
         if (pending_answers.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         ans = pending_answers.pop_front();
         compare_field("status", 9'(ans.status), 9'(status));
         compare_field("entry_index", 9'(ans.entry_index), 9'(entry_index));
         compare_field("export_count", ans.exports, exp_count);
         compare_field("import_count", ans.imports, imp_count);
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [sarl_pkg::CMD_W-1:0]    req_command;
   logic [sarl_pkg::ADDR_W-1:0]   req_address;
   logic [sarl_pkg::SIZE_W-1:0]   req_symbol_size;
   logic                          req_is_global;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [sarl_pkg::STATUS_W-1:0] rsp_status;
   logic [sarl_pkg::ENTRY_W-1:0]  rsp_entry_index;
   logic [sarl_pkg::COUNT_W-1:0]  rsp_export_count;
   logic [sarl_pkg::COUNT_W-1:0]  rsp_import_count;

   symbol_table_checker_type table_check = new();
   int unsigned              requests_sent = 0;
   bit                       calm = 1'b0;

   symbol_address_range_lookup uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_symbol_size  (req_symbol_size),
      .req_is_global    (req_is_global),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_export_count (rsp_export_count),
      .rsp_import_count (rsp_import_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $error("run did not finish in time, %0d responses outstanding",
             table_check.pending_answers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side stall
   initial begin
      int unsigned stall_left, r;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            r = $urandom_range(0, 99);
            if (!calm && r < 14) stall_left = $urandom_range(1, 3);
            else if (!calm && r < 16) stall_left = $urandom_range(15, 60);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         table_check.check_response(rsp_status, rsp_entry_index,
                                    rsp_export_count, rsp_import_count);
   end

   // drive one request and hold it until accepted
   task automatic send_request(logic [sarl_pkg::CMD_W-1:0] command,
                               logic [sarl_pkg::ADDR_W-1:0] address,
                               logic [sarl_pkg::SIZE_W-1:0] size, logic global_bind);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_command     <= command;
      req_address     <= address;
      req_symbol_size <= size;
      req_is_global   <= global_bind;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      table_check.note_request(command, address, size, global_bind);
      requests_sent++;
   endtask

   // hold off until every predicted response has come back
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (table_check.pending_answers.size() != 0) @(posedge clock);
   endtask

   // append with start near base, sometimes a tie, zero or anywhere
   task automatic add_symbol(logic [sarl_pkg::ADDR_W-1:0] base);
      logic [sarl_pkg::ADDR_W-1:0] address;
      logic [sarl_pkg::SIZE_W-1:0] size;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10 && table_check.sorted_fill > 0)
         address = table_check.starts[$urandom_range(0, table_check.sorted_fill - 1)];
      else if (r < 15)
         address = '0;
      else if (r < 20)
         address = rand64();
      else
         address = base + 64'($urandom_range(0, 8191));
      r = $urandom_range(0, 99);
      if (r < 8) size = '0;
      else if (r < 14) size = rand64();
      else if (r < 17) size = '1;
      else size = 64'($urandom_range(1, 256));
      send_request(sarl_pkg::CMD_APPEND, address, size, 1'($urandom_range(0, 1)));
   endtask

   // lookup aimed at a stored range: its start, inside, last byte, just past, just before
   task automatic query_symbol();
      logic [sarl_pkg::ADDR_W-1:0] address, s;
      logic [sarl_pkg::SIZE_W-1:0] z;
      logic [sarl_pkg::CMD_W-1:0]  command;
      int unsigned                 r;
      command = $urandom_range(0, 1) ? sarl_pkg::CMD_EXACT : sarl_pkg::CMD_CONTAIN;
      r = $urandom_range(0, 99);
      if (table_check.sorted_fill == 0 || r < 12) begin
         address = (r < 3) ? '0 : rand64();
      end else begin
         r = $urandom_range(0, table_check.sorted_fill - 1);
         s = table_check.starts[r];
         z = table_check.sizes[r];
         case ($urandom_range(0, 4))
            0: address = s;
            1: address = s + rand64() % z;
            2: address = s + z - 1;
            3: address = s + z;
            default: address = s - 1;
         endcase
      end
      send_request(command, address, rand64(), 1'($urandom_range(0, 1)));
   endtask

   // base of a cluster of symbols
   function automatic logic [sarl_pkg::ADDR_W-1:0] pick_base();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 64'hFFFF_FFFF_FFFF_E000;
         default: return rand64();
      endcase
   endfunction

   // build a table and query it
   task automatic build_and_query();
      int unsigned n_add, n_look;
      logic [sarl_pkg::ADDR_W-1:0] base;
      if ($urandom_range(0, 2) != 0)
         send_request(sarl_pkg::CMD_CLEAR, rand64(), rand64(), 1'b1);
      base = pick_base();
      n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 16);
      repeat (n_add) add_symbol(base);
      n_look = $urandom_range(n_add, 2 * n_add + 4);
      repeat (n_look) query_symbol();
   endtask

   // fill the table past its capacity with lookups mixed in
   task automatic fill_table();
      logic [sarl_pkg::ADDR_W-1:0] base;
      int unsigned k;
      wait_idle();
      send_request(sarl_pkg::CMD_CLEAR, '0, '0, 1'b0);
      base = pick_base();
      for (k = 0; k < sarl_pkg::MAX_SYMBOLS + 6; k++) begin
         add_symbol(base);
         if (k % 8 == 7) query_symbol();
      end
      repeat (20) query_symbol();
   endtask

   // fully random requests
   task automatic noise_burst();
      repeat ($urandom_range(5, 30))
         send_request(2'($urandom_range(0, 3)),
                      $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 300)),
                      $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 300)),
                      1'($urandom_range(0, 1)));
   endtask

   // extremes, ties, zero start and size, empty table, clear
   task automatic directed_checks();
      send_request(sarl_pkg::CMD_EXACT,   64'h5, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h5, '0, 1'b0);
      send_request(sarl_pkg::CMD_APPEND,  64'h0, 64'h10, 1'b1);
      send_request(sarl_pkg::CMD_APPEND,  64'h100, 64'h0, 1'b1);
      send_request(sarl_pkg::CMD_APPEND,  64'h100, 64'h10, 1'b0);
      send_request(sarl_pkg::CMD_APPEND,  64'h100, 64'h40, 1'b1);
      send_request(sarl_pkg::CMD_APPEND,  64'hFFFF_FFFF_FFFF_FFF0, '1, 1'b1);
      send_request(sarl_pkg::CMD_APPEND,  64'h80, 64'h8, 1'b0);
      send_request(sarl_pkg::CMD_EXACT,   64'h100, '1, 1'b1);
      send_request(sarl_pkg::CMD_EXACT,   64'h0, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h0, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h105, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h140, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h13F, '0, 1'b0);
      send_request(sarl_pkg::CMD_EXACT,   64'h101, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, '1, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h7F, '0, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h80, '0, 1'b0);
      send_request(sarl_pkg::CMD_EXACT,   '1, '0, 1'b0);
      send_request(sarl_pkg::CMD_APPEND,  '1, 64'h1, 1'b0);
      send_request(sarl_pkg::CMD_EXACT,   '1, '0, 1'b0);
      send_request(sarl_pkg::CMD_CLEAR,   '1, '1, 1'b1);
      send_request(sarl_pkg::CMD_CONTAIN, 64'h100, '0, 1'b0);
      send_request(sarl_pkg::CMD_APPEND,  64'h1, '1, 1'b0);
      send_request(sarl_pkg::CMD_CONTAIN, '1, '0, 1'b0);
   endtask

   // reset, stimulus, drain, verdict
   initial begin
      int unsigned phase;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = sarl_pkg::CMD_APPEND;
      req_address     = '0;
      req_symbol_size = '0;
      req_is_global   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      directed_checks();
      phase = 0;
      while (requests_sent < 800) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) wait_idle();
         if (phase == 2) fill_table();
         else if ($urandom_range(0, 5) == 0) noise_burst();
         else build_and_query();
         phase++;
      end
      calm = 1'b0;
      wait_idle();
      repeat (64) @(posedge clock);

      $display("covered %0d requests: %0d appends (%0d refused on a full table), %0d clears",
               requests_sent, table_check.appends, table_check.refusals, table_check.clears);
      $display("  %0d exact and containing lookups, %0d of them hits",
               table_check.lookups, table_check.lookup_hits);
      if (table_check.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
